[sv/altp_pkg.sv]
// ----------------------------------------------------------------------------
// altp_pkg
// Shared types and constants for the absolute loader tape parser.
// ----------------------------------------------------------------------------
package altp_pkg;

    localparam int ADDR_BITS_DEFAULT = 16;

    localparam logic [7:0]  SYNC_FIRST_BYTE  = 8'd1;
    localparam logic [7:0]  SYNC_SECOND_BYTE = 8'd0;
    localparam logic [15:0] END_ADDRESS      = 16'd1;
    localparam logic [15:0] BLOCK_OVERHEAD   = 16'd6;

    typedef enum logic [3:0] {
        PH_SYNC1  = 4'd0,
        PH_SYNC0  = 4'd1,
        PH_CNT_LO = 4'd2,
        PH_CNT_HI = 4'd3,
        PH_ADR_LO = 4'd4,
        PH_ADR_HI = 4'd5,
        PH_DAT_LO = 4'd6,
        PH_DAT_HI = 4'd7,
        PH_CHECK  = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        EV_WRITE = 2'd0,
        EV_DONE  = 2'd1,
        EV_ERROR = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic [7:0] tape_byte;
        logic       end_of_tape;
    } tape_item_t;

endpackage

[sv/altp_in_reg.sv]
// ----------------------------------------------------------------------------
// altp_in_reg
// Input register holding one tape transaction until the parser takes it.
// ----------------------------------------------------------------------------
module altp_in_reg
    import altp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  tape_item_t s_item,
    output logic       item_valid,
    output tape_item_t item,
    input  logic       item_take
);

    logic       valid_reg;
    logic       valid_next;
    tape_item_t item_reg;

    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

[sv/altp_parser.sv]
// ----------------------------------------------------------------------------
// altp_parser
// Block format phase machine with checksum adder and the result register.
// ----------------------------------------------------------------------------
module altp_parser
    import altp_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEFAULT
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_valid,
    input  tape_item_t  item,
    output logic        item_take,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_kind,
    output logic [15:0] m_word_address,
    output logic [15:0] m_word_data
);

    localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDR_BITS) - 32'd1);

    phase_t      phase_reg, phase_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] load_reg, load_next;
    logic [7:0]  low_reg, low_next;
    logic        halted_reg, halted_next;

    logic        out_valid_reg, out_valid_next;
    event_kind_t kind_reg, kind_next;
    logic [15:0] waddr_reg, waddr_next;
    logic [15:0] wdata_reg, wdata_next;

    logic        has_result;
    logic [7:0]  b;
    logic [7:0]  sum_add;
    logic [15:0] addr_full;
    logic [15:0] count_less;
    logic [15:0] count_dec;

    assign item_take      = item_valid && (!out_valid_reg || m_ready);
    assign m_valid        = out_valid_reg;
    assign m_event_kind   = kind_reg;
    assign m_word_address = waddr_reg;
    assign m_word_data    = wdata_reg;

    assign b          = item.tape_byte;
    assign sum_add    = sum_reg + b;
    assign addr_full  = {b, load_reg[7:0]};
    assign count_less = count_reg - BLOCK_OVERHEAD;
    assign count_dec  = count_reg - 16'd1;

    always_comb begin
        phase_next  = phase_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        load_next   = load_reg;
        low_next    = low_reg;
        halted_next = halted_reg;
        has_result  = 1'b0;
        kind_next   = EV_WRITE;
        waddr_next  = 16'd0;
        wdata_next  = 16'd0;

        if (item_take && !halted_reg) begin
            if (item.end_of_tape) begin
                has_result  = 1'b1;
                halted_next = 1'b1;
                phase_next  = PH_SYNC1;
                case (phase_reg)
                    PH_CNT_LO, PH_CNT_HI, PH_ADR_LO, PH_ADR_HI,
                    PH_DAT_LO, PH_DAT_HI, PH_CHECK: begin
                        kind_next = EV_ERROR;
                    end
                    default: begin
                        kind_next = EV_DONE;
                    end
                endcase
            end else begin
                case (phase_reg)
                    PH_SYNC0: begin
                        sum_next   = sum_add;
                        phase_next = (b == SYNC_SECOND_BYTE) ? PH_CNT_LO : PH_SYNC1;
                    end
                    PH_CNT_LO: begin
                        sum_next   = sum_add;
                        count_next = {8'd0, b};
                        phase_next = PH_CNT_HI;
                    end
                    PH_CNT_HI: begin
                        sum_next   = sum_add;
                        count_next = {b, count_reg[7:0]};
                        phase_next = PH_ADR_LO;
                    end
                    PH_ADR_LO: begin
                        sum_next   = sum_add;
                        load_next  = {8'd0, b};
                        phase_next = PH_ADR_HI;
                    end
                    PH_ADR_HI: begin
                        sum_next  = sum_add;
                        load_next = addr_full;
                        if (addr_full == END_ADDRESS) begin
                            has_result  = 1'b1;
                            halted_next = 1'b1;
                            kind_next   = EV_DONE;
                            phase_next  = PH_SYNC1;
                        end else if (count_reg == 16'd0) begin
                            phase_next = PH_SYNC1;
                        end else if (count_less[0]) begin
                            has_result  = 1'b1;
                            halted_next = 1'b1;
                            kind_next   = EV_ERROR;
                            phase_next  = PH_SYNC1;
                        end else begin
                            count_next = {1'b0, count_less[15:1]};
                            load_next  = {1'b0, addr_full[15:1]} & ADDR_MASK;
                            phase_next = (count_less[15:1] == 15'd0) ? PH_CHECK : PH_DAT_LO;
                        end
                    end
                    PH_DAT_LO: begin
                        sum_next   = sum_add;
                        low_next   = b;
                        phase_next = PH_DAT_HI;
                    end
                    PH_DAT_HI: begin
                        sum_next   = sum_add;
                        has_result = 1'b1;
                        kind_next  = EV_WRITE;
                        waddr_next = load_reg & ADDR_MASK;
                        wdata_next = {b, low_reg};
                        load_next  = (load_reg + 16'd1) & ADDR_MASK;
                        count_next = count_dec;
                        phase_next = (count_dec == 16'd0) ? PH_CHECK : PH_DAT_LO;
                    end
                    PH_CHECK: begin
                        sum_next   = sum_add;
                        phase_next = PH_SYNC1;
                        if (sum_add != 8'd0) begin
                            has_result  = 1'b1;
                            halted_next = 1'b1;
                            kind_next   = EV_ERROR;
                        end
                    end
                    default: begin
                        phase_next = PH_SYNC1;
                        if (b == SYNC_FIRST_BYTE) begin
                            sum_next   = SYNC_FIRST_BYTE;
                            phase_next = PH_SYNC0;
                        end
                    end
                endcase
            end
        end

        if (has_result) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SYNC1;
            sum_reg       <= 8'd0;
            count_reg     <= 16'd0;
            load_reg      <= 16'd0;
            low_reg       <= 8'd0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            load_reg      <= load_next;
            low_reg       <= low_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (has_result) begin
            kind_reg  <= kind_next;
            waddr_reg <= waddr_next;
            wdata_reg <= wdata_next;
        end
    end

endmodule

[sv/absolute_loader_tape_parser_core.sv]
// ----------------------------------------------------------------------------
// absolute_loader_tape_parser_core
// Parses an absolute loader paper tape byte stream into word writes,
// a finish event or a format error event.
//
//   Channel  Direction  Payload
//   s_       in         s_tape_byte, s_end_of_tape
//   m_       out        m_event_kind, m_word_address, m_word_data
//
// One tape byte is accepted per cycle unless the result register stalls; a
// result is presented once its byte has passed from the input register
// through the phase machine and byte adder into the result register.
// Synchronous active-low reset returns to sync search and clears the halt.
// A stalled result register holds the input register, which then stalls s_.
// ----------------------------------------------------------------------------
module absolute_loader_tape_parser_core
    import altp_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEFAULT
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_tape_byte,
    input  logic        s_end_of_tape,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_kind,
    output logic [15:0] m_word_address,
    output logic [15:0] m_word_data
);

    tape_item_t s_item;
    tape_item_t item;
    logic       item_valid;
    logic       item_take;

    assign s_item.tape_byte   = s_tape_byte;
    assign s_item.end_of_tape = s_end_of_tape;

    altp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    altp_parser #(
        .ADDR_BITS (ADDR_BITS)
    ) u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_valid     (item_valid),
        .item           (item),
        .item_take      (item_take),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_word_address (m_word_address),
        .m_word_data    (m_word_data)
    );

endmodule
